// ===== sv/grid_inverse_cdf_sampler_defines.svh =====
// Assertion macros used by the checker file.
`ifndef GRID_INVERSE_CDF_SAMPLER_DEFINES_SVH
`define GRID_INVERSE_CDF_SAMPLER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define GICS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define GICS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gics_pkg.sv =====
package gics_pkg;

    // Widths of the stream payloads; the two data widths are byte-padded.
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_TUSER_W = 2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_AREA,
        ST_ACCUM,
        ST_TGT,
        ST_SRCH,
        ST_SRCHW,
        ST_CELL,
        ST_NORM,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } gics_state_t;

endpackage

// ===== sv/gics_divider.sv =====
// Restoring divider: quotient = floor((num << 32) / den), one bit per cycle.
// num <= den < 2^32, so the quotient fits 33 bits.
module gics_divider
    import gics_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [32:0] quot
);

    logic [32:0] rem_reg, rem_next;
    logic [32:0] quot_reg, quot_next;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    // One shift-and-subtract step per cycle; 33 steps in total.
    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, 1'b0} - {2'b0, den_reg};
        if (start) begin
            rem_next  = {1'b0, num};
            quot_next = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == 6'd32) begin
                // First quotient bit compares num itself with den.
                if (rem_reg >= {1'b0, den_reg}) begin
                    rem_next  = rem_reg - {1'b0, den_reg};
                    quot_next = 33'd1;
                end
            end else begin
                if (!trial[33]) begin
                    rem_next  = trial[32:0];
                    quot_next = {quot_reg[31:0], 1'b1};
                end else begin
                    rem_next  = {rem_reg[31:0], 1'b0};
                    quot_next = {quot_reg[31:0], 1'b0};
                end
            end
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== sv/grid_inverse_cdf_sampler.sv =====
// Channel | Beat contents                                     | Handshake
// s_      | grid_value, density, uniform_fraction, last_point | s_tvalid/s_tready
// m_      | sample_value, sum_saturated, degenerate           | m_tvalid/m_tready
//
// A grid point that is not last goes through a memory read of the
// previous point, the area multiply and the accumulate with write-back.
// The first point of a set skips the multiply, and a point that
// arrives once the store is full is dropped in its accept cycle.
// A last point adds the draw: a linear search over the stored points
// (one memory read port), up to 32 normalize shifts and the divide.
// Reset is synchronous on aresetn and empties the set; the memories need
// no clearing. The result waits in its output register while m_tready is low.
module grid_inverse_cdf_sampler
    import gics_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // grid_value[31:0], density[63:32]
    input  logic [15:0]          s_tuser,  // uniform_fraction[15:0]
    input  logic                 s_tlast,  // last_point
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // sample_value[31:0]
    output logic [M_TUSER_W-1:0] m_tuser   // sum_saturated[0], degenerate[1]
);

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = AW + 1;

    gics_state_t state_reg, state_next;

    // Point storage: coordinates and cumulative mass, one read port each.
    logic [31:0] grid_mem [MAX_POINTS];
    logic [63:0] cum_mem  [MAX_POINTS];
    logic [31:0] grid_rd;
    logic [63:0] cum_rd;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0] wr_grid;
    logic [63:0] wr_cum;

    logic [CW-1:0] count_reg;
    logic [31:0] prev_d_reg;
    logic        sat_reg;
    logic [31:0] g_reg;
    logic [31:0] d_reg;
    logic [15:0] frac_reg;
    logic        last_reg;
    logic [32:0] span_reg;
    logic [63:0] area_reg;
    logic [63:0] u_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0] glo_reg;
    logic [63:0] clo_reg;
    logic [63:0] num_reg;
    logic [63:0] den_reg;
    logic [31:0] ghi_reg;
    logic [31:0] out_data_reg;
    logic        out_sat_reg;
    logic        out_deg_reg;
    logic [65:0] prod_reg;
    logic        mstep_reg;

    logic        div_start;
    logic        div_done;
    logic [32:0] div_quot;

    logic        s_acc;
    logic        full;
    logic [32:0] span_now;
    logic [64:0] sum_ext;
    logic [63:0] total;

    assign s_acc = s_tvalid && s_tready;
    assign full  = (count_reg == CW'(MAX_POINTS));
    assign span_now = {g_reg[31], g_reg} - {grid_rd[31], grid_rd};
    assign sum_ext  = {1'b0, clo_reg} + {1'b0, area_reg};
    assign total    = clo_reg;

    gics_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg[31:0]),
        .den     (den_reg[31:0]),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Memory ports: synchronous read, one write per cycle.
    always_ff @(posedge aclk) begin
        grid_rd <= grid_mem[rd_addr];
        cum_rd  <= cum_mem[rd_addr];
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_grid;
            cum_mem[wr_addr]  <= wr_cum;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:  if (s_acc) begin
                if (full) state_next = s_tlast ? ST_TGT : ST_LOAD;
                else if (count_reg == '0) state_next = ST_ACCUM;
                else state_next = ST_AREA;
            end
            ST_AREA:  state_next = ST_ACCUM;
            ST_ACCUM: state_next = last_reg ? ST_TGT : ST_LOAD;
            ST_TGT:   state_next = ST_SRCH;
            ST_SRCH:  state_next = ST_SRCHW;
            ST_SRCHW: begin
                if (idx_reg == '0) state_next = ST_OUT;
                else if ((idx_reg == count_reg - CW'(1)) || (cum_rd >= u_reg))
                    state_next = ST_CELL;
                else state_next = ST_SRCH;
            end
            ST_CELL:  state_next = ST_NORM;
            ST_NORM:  begin
                if (den_reg == '0) state_next = ST_OUT;
                else if (den_reg[63:32] == '0) state_next = ST_DIV;
            end
            ST_DIV:   if (div_done) state_next = ST_MUL;
            ST_MUL:   if (mstep_reg) state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    // Output and memory control decode.
    always_comb begin
        s_tready  = (state_reg == ST_LOAD);
        m_tvalid  = (state_reg == ST_OUT);
        div_start = (state_reg == ST_NORM) && (den_reg != '0) && (den_reg[63:32] == '0);
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = count_reg[AW-1:0];
        wr_grid   = g_reg;
        wr_cum    = '0;
        case (state_reg)
            ST_LOAD:  rd_addr = AW'(count_reg - CW'(1));
            ST_ACCUM: begin
                wr_en  = 1'b1;
                wr_cum = (count_reg == '0) ? 64'd0 :
                         ($signed(span_reg) > 0 ? (sum_ext[64] ? '1 : sum_ext[63:0])
                                                : clo_reg);
            end
            ST_SRCH:  rd_addr = idx_reg[AW-1:0];
            ST_SRCHW: rd_addr = AW'(idx_reg - CW'(1));
            ST_CELL:  rd_addr = AW'(idx_reg - CW'(1));
            default:  rd_addr = '0;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            prev_d_reg <= '0;
            sat_reg    <= 1'b0;
            mstep_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_LOAD: if (s_acc) begin
                    g_reg    <= s_tdata[31:0];
                    d_reg    <= s_tdata[63:32];
                    frac_reg <= s_tuser;
                    last_reg <= s_tlast;
                    // clo_reg already holds the running total when full.
                end
                ST_AREA: begin
                    // Trapezoid area floor(span * dsum / 2) from the registered read.
                    span_reg <= span_now;
                    clo_reg  <= cum_rd;
                    area_reg <= span_now[31:0] * (({1'b0, d_reg} + {1'b0, prev_d_reg}) >> 1)
                              + ((d_reg[0] ^ prev_d_reg[0]) ? 64'(span_now[31:1]) : 64'd0);
                end
                ST_ACCUM: begin
                    if (count_reg != '0 && $signed(span_reg) > 0 && sum_ext[64])
                        sat_reg <= 1'b1;
                    clo_reg    <= wr_cum;
                    prev_d_reg <= d_reg;
                    count_reg  <= count_reg + CW'(1);
                end
                ST_TGT: begin
                    u_reg   <= (total >> 16) * 64'(frac_reg)
                             + (((total & 64'hFFFF) * 64'(frac_reg)) >> 16);
                    idx_reg <= (total == '0 || count_reg < CW'(2)) ? CW'(0) : CW'(1);
                    out_sat_reg <= sat_reg;
                    out_deg_reg <= (total == '0 || count_reg < CW'(2));
                end
                ST_SRCHW: begin
                    if (idx_reg == '0) begin
                        out_data_reg <= grid_rd;
                    end else begin
                        ghi_reg <= grid_rd;
                        den_reg <= cum_rd;
                        if (!((idx_reg == count_reg - CW'(1)) || (cum_rd >= u_reg)))
                            idx_reg <= idx_reg + CW'(1);
                    end
                end
                ST_CELL: begin
                    // Lower neighbor arrived; form clamped numerator and denominator.
                    glo_reg      <= grid_rd;
                    out_data_reg <= grid_rd;
                    if (den_reg <= cum_rd || $signed(ghi_reg) <= $signed(grid_rd)) begin
                        den_reg <= '0;
                    end else begin
                        den_reg <= den_reg - cum_rd;
                        num_reg <= (u_reg > cum_rd) ?
                                   ((u_reg - cum_rd > den_reg - cum_rd) ? den_reg - cum_rd
                                                                         : u_reg - cum_rd)
                                   : 64'd0;
                    end
                end
                ST_NORM: if (den_reg[63:32] != '0) begin
                    den_reg <= den_reg >> 1;
                    num_reg <= num_reg >> 1;
                end
                ST_DIV: begin
                    mstep_reg <= 1'b0;
                    span_reg  <= {ghi_reg[31], ghi_reg} - {glo_reg[31], glo_reg};
                end
                ST_MUL: begin
                    if (!mstep_reg) begin
                        prod_reg <= 66'(span_reg[32:0]) * 66'(div_quot);
                        mstep_reg <= 1'b1;
                    end else begin
                        out_data_reg <= glo_reg + prod_reg[63:32];
                    end
                end
                ST_OUT: if (m_tready) begin
                    count_reg  <= '0;
                    prev_d_reg <= '0;
                    sat_reg    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = {out_deg_reg, out_sat_reg};

endmodule

// ===== sv/grid_inverse_cdf_sampler_checker.sv =====
`include "grid_inverse_cdf_sampler_defines.svh"

module grid_inverse_cdf_sampler_checker
    import gics_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // The block never takes a point while a result is offered.
    `GICS_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready, "input taken during output")

    // A result stalled by the sink holds its payload.
    `GICS_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // A point that is not last never yields a result in the next cycle.
    `GICS_ASSERT_NXT(a_no_spurious, aclk, aresetn, s_tvalid && s_tready && !s_tlast, !m_tvalid, "result without last point")

    // A delivered result is followed by readiness for the next set.
    `GICS_ASSERT_NXT(a_reopen, aclk, aresetn, m_tvalid && m_tready, s_tready && !m_tvalid, "block did not reopen after result")

endmodule

bind grid_inverse_cdf_sampler grid_inverse_cdf_sampler_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
